/* design/msp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the multi-axis step pulse generator.
package msp_pkg;

    localparam int MOTORS_DEF    = 8;
    localparam int FRAC_BITS_DEF = 30;
    localparam int TICK_BITS_DEF = 32;

    typedef enum logic [1:0] {
        FN_TICK  = 2'd0,
        FN_LOAD  = 2'd1,
        FN_START = 2'd2,
        FN_HALT  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    // One word of the channel memory.
    typedef struct packed {
        logic [31:0] steps_left;
        logic [31:0] rate;
        logic [31:0] rate_delta;
        logic [31:0] decel_step;
        logic [31:0] plateau;
        logic [31:0] accumulator;
    } t_chan;

endpackage

/* design/msp_chan_engine.sv */
`timescale 1ns / 1ps
// Channel memory with the two-stage rate/accumulator read-modify-write pipeline.
module msp_chan_engine
    import msp_pkg::*;
#(
    parameter int MOTORS    = MOTORS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int TICK_BITS = TICK_BITS_DEF,
    localparam int IW       = (MOTORS > 1) ? $clog2(MOTORS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [IW-1:0]        i_wr_idx,
    input  t_chan                i_wr_chan,
    input  logic [TICK_BITS-1:0] i_wr_event,
    input  logic                 i_rd_en,
    input  logic [IW-1:0]        i_rd_idx,
    input  logic [MOTORS-1:0]    i_live,
    input  logic [MOTORS-1:0]    i_stops,
    input  logic [TICK_BITS-1:0] i_tick_now,
    input  logic [TICK_BITS-1:0] i_accel_end,
    input  logic [TICK_BITS-1:0] i_decel_start,
    input  logic [TICK_BITS-1:0] i_block_ticks,
    output logic [MOTORS-1:0]    o_stop_hit,
    output logic [MOTORS-1:0]    o_step_hit,
    output logic [MOTORS-1:0]    o_empty_hit,
    output logic                 o_busy
);

    localparam logic [31:0] STEP_UNIT = 32'd1 << FRAC_BITS;

    t_chan                r_mem     [MOTORS];
    logic [TICK_BITS-1:0] r_evt_mem [MOTORS];

    t_chan                r_q;
    logic [TICK_BITS-1:0] r_q_evt;
    logic                 r_rd_vld;
    logic [IW-1:0]        r_rd_idx;

    t_chan                r_s2, n_s2;
    logic [TICK_BITS-1:0] r_s2_evt, n_s2_evt;
    logic                 r_s2_vld;
    logic [IW-1:0]        r_s2_idx;

    logic                 w_live, w_stop, w_go;
    logic [31:0]          w_acc_sum;
    logic                 w_fire, w_empty;
    t_chan                w_wb;
    logic                 w_we;
    logic [IW-1:0]        w_widx;
    t_chan                w_wdata;
    logic [TICK_BITS-1:0] w_wevt;

    // Stage 1: rate update and phase switch.
    always_comb begin
        w_live   = r_rd_vld && i_live[r_rd_idx];
        w_stop   = w_live && i_stops[r_rd_idx];
        w_go     = w_live && !w_stop;
        n_s2     = r_q;
        n_s2_evt = r_q_evt;
        n_s2.rate = r_q.rate + r_q.rate_delta;
        if (i_tick_now == r_q_evt) begin
            if (i_tick_now == i_accel_end) begin
                n_s2.rate_delta = '0;
                if (i_decel_start < i_block_ticks) begin
                    n_s2_evt = i_decel_start;
                    if (i_tick_now != i_decel_start) begin
                        n_s2.rate = r_q.plateau;
                    end
                end
            end
            if (i_tick_now == i_decel_start) begin
                n_s2.rate_delta = r_q.decel_step;
            end
        end
        // non-positive rate forces a step
        if (n_s2.rate == '0 || n_s2.rate[31]) begin
            n_s2.accumulator = STEP_UNIT;
            n_s2.rate        = '0;
        end
    end

    // Stage 2: accumulate, step, write back.
    always_comb begin
        w_acc_sum = r_s2.accumulator + r_s2.rate;
        w_fire    = |w_acc_sum[31:FRAC_BITS];
        w_wb      = r_s2;
        if (w_fire) begin
            w_wb.accumulator = w_acc_sum - STEP_UNIT;
            w_wb.steps_left  = r_s2.steps_left - 32'd1;
        end else begin
            w_wb.accumulator = w_acc_sum;
        end
        w_empty = w_fire && (r_s2.steps_left == 32'd1);
    end

    // Load writes only while the pipeline is empty.
    always_comb begin
        w_we    = r_s2_vld || i_wr_en;
        w_widx  = r_s2_vld ? r_s2_idx : i_wr_idx;
        w_wdata = r_s2_vld ? w_wb : i_wr_chan;
        w_wevt  = r_s2_vld ? r_s2_evt : i_wr_event;
    end

    always_comb begin
        o_stop_hit  = '0;
        o_step_hit  = '0;
        o_empty_hit = '0;
        if (w_stop) begin
            o_stop_hit[r_rd_idx] = 1'b1;
        end
        if (r_s2_vld && w_fire) begin
            o_step_hit[r_s2_idx] = 1'b1;
        end
        if (r_s2_vld && w_empty) begin
            o_empty_hit[r_s2_idx] = 1'b1;
        end
    end

    assign o_busy = r_rd_vld || r_s2_vld;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_widx]     <= w_wdata;
            r_evt_mem[w_widx] <= w_wevt;
        end
        if (i_rd_en) begin
            r_q     <= r_mem[i_rd_idx];
            r_q_evt <= r_evt_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= i_rd_idx;
        r_s2_idx <= r_rd_idx;
        r_s2     <= n_s2;
        r_s2_evt <= n_s2_evt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_rd_en;
            r_s2_vld <= w_go;
        end
    end

endmodule

/* design/multi_axis_step_pulse_generator.sv */
`timescale 1ns / 1ps
// Load, start and halt transactions: result strobe on the cycle after acceptance, busy stays low.
// Tick on a running block: busy while each scanned motor's channel is read in turn and the
// engine pipeline drains; only live, unstopped channels are written back; strobe as busy falls.
// A new transaction may be accepted in the strobe cycle; the receiver cannot stall results.
// Reset is synchronous, active low: control state clears, motors_in_use returns to 8.
// Channel memory is not cleared; a channel without its nonzero-steps flag is never used.
module multi_axis_step_pulse_generator
    import msp_pkg::*;
#(
    parameter int MOTORS    = MOTORS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int TICK_BITS = TICK_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_wdata,
    input  logic [1:0]         i_func,
    input  logic [2:0]         i_motor_index,
    input  logic               i_direction,
    input  logic [31:0]        i_steps_to_move,
    input  logic signed [31:0] i_start_rate,
    input  logic signed [31:0] i_accel_delta,
    input  logic signed [31:0] i_decel_delta,
    input  logic signed [31:0] i_plateau_rate,
    input  logic [31:0]        i_tick_a,
    input  logic [31:0]        i_tick_b,
    input  logic [31:0]        i_tick_c,
    input  logic [7:0]         i_stop_mask,
    output logic               o_strobe,
    output logic [7:0]         o_step_mask,
    output logic [7:0]         o_direction_mask,
    output logic [7:0]         o_moving_mask,
    output logic               o_block_done,
    output logic               o_running
);

    localparam int IW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int CW = $clog2(MOTORS + 1);

    // control state
    t_state               r_state, n_state;
    logic [IW-1:0]        r_idx, n_idx;
    logic [3:0]           r_miu;
    logic [MOTORS-1:0]    r_dir, n_dir;
    logic [MOTORS-1:0]    r_live, n_live;       // channel loaded with nonzero steps, not yet used up, stopped or halted
    logic [MOTORS-1:0]    r_moving, n_moving;
    logic [TICK_BITS-1:0] r_accel_end, n_accel_end;
    logic [TICK_BITS-1:0] r_decel_start, n_decel_start;
    logic [TICK_BITS-1:0] r_block_ticks, n_block_ticks;
    logic [TICK_BITS-1:0] r_tick_now, n_tick_now;
    logic                 r_active, n_active;
    logic                 r_strobe, n_strobe;

    // per-tick working values
    logic [MOTORS-1:0]    r_stops, n_stops;
    logic [MOTORS-1:0]    r_step_acc, n_step_acc;

    // result registers
    logic [MOTORS-1:0]    r_res_step, n_res_step;
    logic [MOTORS-1:0]    r_res_dir, n_res_dir;
    logic [MOTORS-1:0]    r_res_mov, n_res_mov;
    logic                 r_res_done, n_res_done;
    logic                 r_res_run, n_res_run;

    logic                 w_accept;
    t_func                w_func;
    logic [CW-1:0]        w_scanned;
    logic [MOTORS-1:0]    w_scan_mask;
    logic [MOTORS-1:0]    w_stops;
    logic [CW-1:0]        w_idx_ext, w_idx_nxt;
    logic                 w_ld_ok;
    logic [IW-1:0]        w_ld_idx;
    logic                 w_wr_en, w_rd_en;
    t_chan                w_wr_chan;
    logic [MOTORS-1:0]    w_stop_hit, w_step_hit, w_empty_hit;
    logic                 w_eng_busy;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_func   = t_func'(i_func);

    // register values above MOTORS scan all channels
    assign w_scanned = ({1'b0, r_miu} > 5'(MOTORS)) ? CW'(MOTORS) : CW'(r_miu);

    always_comb begin
        for (int m = 0; m < MOTORS; m++) begin
            w_scan_mask[m] = (CW'(m) < w_scanned);
        end
    end

    for (genvar g = 0; g < MOTORS; g++) begin : g_stops
        if (g < 8) begin : g_in
            assign w_stops[g] = i_stop_mask[g];
        end else begin : g_none
            assign w_stops[g] = 1'b0;
        end
    end

    assign w_idx_ext = CW'(r_idx);
    assign w_idx_nxt = w_idx_ext + CW'(1);

    // loads past the last channel are dropped
    assign w_ld_ok  = (int'(i_motor_index) < MOTORS);
    assign w_ld_idx = IW'(i_motor_index);

    always_comb begin
        w_wr_chan.steps_left  = i_steps_to_move;
        w_wr_chan.rate        = i_start_rate;
        w_wr_chan.rate_delta  = i_accel_delta;
        w_wr_chan.decel_step  = i_decel_delta;
        w_wr_chan.plateau     = i_plateau_rate;
        w_wr_chan.accumulator = '0;
    end

    msp_chan_engine #(
        .MOTORS    (MOTORS),
        .FRAC_BITS (FRAC_BITS),
        .TICK_BITS (TICK_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (w_wr_en),
        .i_wr_idx      (w_ld_idx),
        .i_wr_chan     (w_wr_chan),
        .i_wr_event    (i_tick_a[TICK_BITS-1:0]),
        .i_rd_en       (w_rd_en),
        .i_rd_idx      (r_idx),
        .i_live        (r_live),
        .i_stops       (r_stops),
        .i_tick_now    (r_tick_now),
        .i_accel_end   (r_accel_end),
        .i_decel_start (r_decel_start),
        .i_block_ticks (r_block_ticks),
        .o_stop_hit    (w_stop_hit),
        .o_step_hit    (w_step_hit),
        .o_empty_hit   (w_empty_hit),
        .o_busy        (w_eng_busy)
    );

    // Next state and result
    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_dir         = r_dir;
        n_accel_end   = r_accel_end;
        n_decel_start = r_decel_start;
        n_block_ticks = r_block_ticks;
        n_tick_now    = r_tick_now;
        n_active      = r_active;
        n_stops       = r_stops;
        n_strobe      = 1'b0;
        n_res_step    = r_res_step;
        n_res_dir     = r_res_dir;
        n_res_mov     = r_res_mov;
        n_res_done    = r_res_done;
        n_res_run     = r_res_run;
        w_wr_en       = 1'b0;
        w_rd_en       = 1'b0;

        // pipeline events: external stop, step, last step used up
        n_live     = r_live & ~(w_stop_hit | w_empty_hit);
        n_moving   = r_moving & ~(w_stop_hit | w_empty_hit);
        n_step_acc = r_step_acc | w_step_hit;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_strobe   = 1'b1;
                    n_res_step = '0;
                    n_res_done = 1'b0;
                    case (w_func)
                        FN_TICK: begin
                            // idle tick just reports state
                            if (r_active) begin
                                n_strobe   = 1'b0;
                                n_state    = ST_SCAN;
                                n_idx      = '0;
                                n_stops    = w_stops;
                                n_step_acc = '0;
                            end
                        end
                        FN_LOAD: begin
                            if (!r_active && w_ld_ok) begin
                                w_wr_en          = 1'b1;
                                n_live[w_ld_idx] = |i_steps_to_move;
                                if (|i_steps_to_move) begin
                                    n_dir[w_ld_idx] = i_direction;
                                end
                            end
                        end
                        FN_START: begin
                            if (!r_active) begin
                                n_accel_end   = i_tick_a[TICK_BITS-1:0];
                                n_decel_start = i_tick_b[TICK_BITS-1:0];
                                n_block_ticks = i_tick_c[TICK_BITS-1:0];
                                n_tick_now    = '0;
                                n_moving      = r_live & w_scan_mask;
                                n_active      = |(r_live & w_scan_mask);
                                // empty block finishes at once
                                n_res_done    = ~|(r_live & w_scan_mask);
                            end
                        end
                        FN_HALT: begin
                            n_res_done = r_active;
                            n_active   = 1'b0;
                            n_tick_now = '0;
                            n_moving   = '0;
                            n_live     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                // one channel read per cycle
                w_rd_en = (w_idx_ext < w_scanned);
                if (w_idx_nxt >= w_scanned) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_DRAIN: begin
                if (!w_eng_busy) begin
                    n_strobe   = 1'b1;
                    n_res_step = n_step_acc;
                    n_tick_now = r_tick_now + TICK_BITS'(1);
                    n_res_done = 1'b0;
                    if ((n_moving & w_scan_mask) == '0) begin
                        n_tick_now = '0;
                        n_active   = 1'b0;
                        n_res_done = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (n_strobe) begin
            n_res_dir = n_dir;
            n_res_mov = n_moving & w_scan_mask;
            n_res_run = n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_idx         <= '0;
            r_miu         <= 4'd8;
            r_dir         <= '0;
            r_live        <= '0;
            r_moving      <= '0;
            r_accel_end   <= '0;
            r_decel_start <= '0;
            r_block_ticks <= '0;
            r_tick_now    <= '0;
            r_active      <= 1'b0;
            r_strobe      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_idx         <= n_idx;
            if (i_cfg_we) begin
                r_miu <= i_cfg_wdata;
            end
            r_dir         <= n_dir;
            r_live        <= n_live;
            r_moving      <= n_moving;
            r_accel_end   <= n_accel_end;
            r_decel_start <= n_decel_start;
            r_block_ticks <= n_block_ticks;
            r_tick_now    <= n_tick_now;
            r_active      <= n_active;
            r_strobe      <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stops    <= n_stops;
        r_step_acc <= n_step_acc;
        r_res_step <= n_res_step;
        r_res_dir  <= n_res_dir;
        r_res_mov  <= n_res_mov;
        r_res_done <= n_res_done;
        r_res_run  <= n_res_run;
    end

    // result transaction
    assign o_strobe     = r_strobe;
    assign o_block_done = r_res_done;
    assign o_running    = r_res_run;

    for (genvar g = 0; g < 8; g++) begin : g_out
        if (g < MOTORS) begin : g_chan
            assign o_step_mask[g]      = r_res_step[g];
            assign o_direction_mask[g] = r_res_dir[g];
            assign o_moving_mask[g]    = r_res_mov[g];
        end else begin : g_none
            assign o_step_mask[g]      = 1'b0;
            assign o_direction_mask[g] = 1'b0;
            assign o_moving_mask[g]    = 1'b0;
        end
    end

endmodule

/* design/msp_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the step pulse generator, bound to the top level.
module msp_checker
    import msp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_cfg_we,
    input logic [3:0]         i_cfg_wdata,
    input logic [1:0]         i_func,
    input logic [2:0]         i_motor_index,
    input logic               i_direction,
    input logic [31:0]        i_steps_to_move,
    input logic signed [31:0] i_start_rate,
    input logic signed [31:0] i_accel_delta,
    input logic signed [31:0] i_decel_delta,
    input logic signed [31:0] i_plateau_rate,
    input logic [31:0]        i_tick_a,
    input logic [31:0]        i_tick_b,
    input logic [31:0]        i_tick_c,
    input logic [7:0]         i_stop_mask,
    input logic               o_strobe,
    input logic [7:0]         o_step_mask,
    input logic [7:0]         o_direction_mask,
    input logic [7:0]         o_moving_mask,
    input logic               o_block_done,
    input logic               o_running
);

    // a result never shows while a tick is still scanning
    a_strobe_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // non-tick transactions answer on the next cycle
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func != FN_TICK) |=> o_strobe)
        else $error("missing result after load, start or halt");

    a_done_not_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_block_done) |-> !o_running)
        else $error("block done while still running");

    a_halt_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FN_HALT) |=>
            (o_strobe && !o_running && o_moving_mask == 8'd0))
        else $error("halt left motors moving");

endmodule

bind multi_axis_step_pulse_generator msp_checker u_msp_checker (.*);

/* sim/msp_pulse_checker.sv */
`timescale 1ns / 1ps
// Result checker for the multi-axis step pulse generator: watches both channels and compares.
module msp_pulse_checker
    import msp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  t_func       i_func,
    input  logic [2:0]  i_motor_index,
    input  logic        i_direction,
    input  logic [31:0] i_steps_to_move,
    input  logic [31:0] i_start_rate,
    input  logic [31:0] i_accel_delta,
    input  logic [31:0] i_decel_delta,
    input  logic [31:0] i_plateau_rate,
    input  logic [31:0] i_tick_a,
    input  logic [31:0] i_tick_b,
    input  logic [31:0] i_tick_c,
    input  logic [7:0]  i_stop_mask,
    input  logic        i_strobe,
    input  logic [7:0]  i_step_mask,
    input  logic [7:0]  i_direction_mask,
    input  logic [7:0]  i_moving_mask,
    input  logic        i_block_done,
    input  logic        i_running,
    output int          o_mismatch_count,
    output int          o_pending
);

    localparam int          MOTORS   = MOTORS_DEF;
    localparam logic [31:0] ONE_STEP = 32'd1 << FRAC_BITS_DEF;
    localparam int          REPORTED = 10;

    typedef struct packed {
        logic [7:0] step_mask;
        logic [7:0] dir_mask;
        logic [7:0] moving;
        logic       done;
        logic       running;
    } t_pulse_result;

    // Predicted motion state
    logic [31:0] axis_left   [MOTORS];
    logic [31:0] axis_rate   [MOTORS];
    logic [31:0] axis_delta  [MOTORS];
    logic [31:0] axis_decel  [MOTORS];
    logic [31:0] axis_cruise [MOTORS];
    logic [31:0] axis_event  [MOTORS];
    logic [31:0] axis_phase  [MOTORS];
    logic [7:0]  dir_bits;
    logic [7:0]  moving_bits;
    logic [31:0] accel_end;
    logic [31:0] decel_start;
    logic [31:0] block_len;
    logic [31:0] tick_cnt;
    logic        block_run;
    logic [3:0]  axes_cfg;

    t_pulse_result pulse_results_due[$];
    int            results_seen;

    task automatic clear_motion();
        for (int m = 0; m < MOTORS; m++) axis_left[m] = '0;
        dir_bits    = '0;
        moving_bits = '0;
        accel_end   = '0;
        decel_start = '0;
        block_len   = '0;
        tick_cnt    = '0;
        block_run   = 1'b0;
        axes_cfg    = 4'd8;
    endtask

    // Applies one accepted transaction to the predicted state.
    task automatic advance_axes(output t_pulse_result r);
        int         n;
        int         m;
        logic [7:0] span;
        logic [7:0] stepped;
        logic       done;
        n       = (axes_cfg > MOTORS) ? MOTORS : int'(axes_cfg);
        span    = 8'((9'd1 << n) - 9'd1);
        stepped = '0;
        done    = 1'b0;
        case (i_func)
            FN_TICK: begin
                if (block_run) begin
                    for (m = 0; m < n; m++) begin
                        if (axis_left[m] != 0) begin
                            if (i_stop_mask[m]) begin
                                axis_left[m]   = '0;
                                moving_bits[m] = 1'b0;
                            end else begin
                                axis_rate[m] = axis_rate[m] + axis_delta[m];
                                if (tick_cnt == axis_event[m]) begin
                                    if (tick_cnt == accel_end) begin
                                        axis_delta[m] = '0;
                                        if (decel_start < block_len) begin
                                            axis_event[m] = decel_start;
                                            if (tick_cnt != decel_start)
                                                axis_rate[m] = axis_cruise[m];
                                        end
                                    end
                                    if (tick_cnt == decel_start) axis_delta[m] = axis_decel[m];
                                end
                                // non-positive rate forces a step
                                if (axis_rate[m] == 0 || axis_rate[m][31]) begin
                                    axis_phase[m] = ONE_STEP;
                                    axis_rate[m]  = '0;
                                end
                                axis_phase[m] = axis_phase[m] + axis_rate[m];
                                if (axis_phase[m] >= ONE_STEP) begin
                                    axis_phase[m] = axis_phase[m] - ONE_STEP;
                                    stepped[m]    = 1'b1;
                                    axis_left[m]  = axis_left[m] - 1;
                                    if (axis_left[m] == 0) moving_bits[m] = 1'b0;
                                end
                            end
                        end
                    end
                    tick_cnt = tick_cnt + 1;
                    if ((moving_bits & span) == 0) begin
                        tick_cnt  = '0;
                        block_run = 1'b0;
                        done      = 1'b1;
                    end
                end
            end
            FN_LOAD: begin
                m = int'(i_motor_index);
                if (!block_run && m < MOTORS) begin
                    axis_left[m]   = i_steps_to_move;
                    axis_rate[m]   = i_start_rate;
                    axis_delta[m]  = i_accel_delta;
                    axis_decel[m]  = i_decel_delta;
                    axis_cruise[m] = i_plateau_rate;
                    axis_event[m]  = i_tick_a;
                    axis_phase[m]  = '0;
                    if (i_steps_to_move != 0) dir_bits[m] = i_direction;
                end
            end
            FN_START: begin
                if (!block_run) begin
                    accel_end   = i_tick_a;
                    decel_start = i_tick_b;
                    block_len   = i_tick_c;
                    tick_cnt    = '0;
                    moving_bits = '0;
                    for (m = 0; m < n; m++)
                        if (axis_left[m] != 0) moving_bits[m] = 1'b1;
                    if (moving_bits != 0) block_run = 1'b1;
                    else done = 1'b1;
                end
            end
            default: begin
                done        = block_run;
                block_run   = 1'b0;
                tick_cnt    = '0;
                moving_bits = '0;
                for (m = 0; m < MOTORS; m++) axis_left[m] = '0;
            end
        endcase
        r.step_mask = stepped;
        r.dir_mask  = dir_bits;
        r.moving    = moving_bits & span;
        r.done      = done;
        r.running   = block_run;
    endtask

    always @(posedge i_clk) begin
        t_pulse_result want;
        t_pulse_result got;
        if (!i_rst_n) begin
            clear_motion();
            pulse_results_due.delete();
            results_seen     = 0;
            o_mismatch_count <= 0;
        end else begin
            // the strobe belongs to an older transaction than one accepted on this edge
            if (i_strobe) begin
                got.step_mask = i_step_mask;
                got.dir_mask  = i_direction_mask;
                got.moving    = i_moving_mask;
                got.done      = i_block_done;
                got.running   = i_running;
                if (pulse_results_due.size() == 0) begin
                    if (o_mismatch_count < REPORTED)
                        $display("chk: result %0d with none pending: step=%h dir=%h mov=%h done=%b run=%b",
                                 results_seen, got.step_mask, got.dir_mask, got.moving,
                                 got.done, got.running);
                    o_mismatch_count <= o_mismatch_count + 1;
                end else begin
                    want = pulse_results_due.pop_front();
                    if (want.step_mask !== got.step_mask || want.dir_mask !== got.dir_mask ||
                        want.moving !== got.moving || want.done !== got.done ||
                        want.running !== got.running) begin
                        if (o_mismatch_count < REPORTED)
                            $display("chk: result %0d exp step=%h dir=%h mov=%h done=%b run=%b, got step=%h dir=%h mov=%h done=%b run=%b",
                                     results_seen, want.step_mask, want.dir_mask, want.moving,
                                     want.done, want.running, got.step_mask, got.dir_mask,
                                     got.moving, got.done, got.running);
                        o_mismatch_count <= o_mismatch_count + 1;
                    end
                end
                results_seen++;
            end
            if (i_cfg_we) axes_cfg = i_cfg_wdata;
            if (start && !busy) begin
                advance_axes(want);
                pulse_results_due.push_back(want);
            end
        end
        o_pending <= pulse_results_due.size();
    end

endmodule

/* sim/multi_axis_step_pulse_generator_tb.sv */
`timescale 1ns / 1ps
// Testbench top: stimulus, watchdog and verdict for the multi-axis step pulse generator.
module multi_axis_step_pulse_generator_tb;
    import msp_pkg::*;

    localparam int          CLK_HALF_NS  = 6;     // 12 ns period
    localparam int          RESET_CYCLES = 12;
    localparam int          ITEM_TARGET  = 1950;
    localparam int          CALM_TAIL    = 300;   // last transactions go back to back
    localparam int          STALL_LIMIT  = 1000;  // cycles with no handshake at all
    localparam int          DRAIN_CYCLES = 16;    // outlasts the longest tick scan
    localparam logic [31:0] ONE_STEP     = 32'd1 << FRAC_BITS_DEF;

    // Everything one transaction carries on the data ports.
    typedef struct packed {
        t_func       func;
        logic [2:0]  motor;
        logic        dir;
        logic [31:0] steps;
        logic [31:0] start_rate;
        logic [31:0] accel;
        logic [31:0] decel;
        logic [31:0] plateau;
        logic [31:0] tick_a;
        logic [31:0] tick_b;
        logic [31:0] tick_c;
        logic [7:0]  stops;
    } t_motion_cmd;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        start     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [3:0]  cfg_wdata = 4'd0;
    t_motion_cmd drv       = '0;

    logic        busy;
    logic        o_strobe;
    logic [7:0]  o_step_mask;
    logic [7:0]  o_direction_mask;
    logic [7:0]  o_moving_mask;
    logic        o_block_done;
    logic        o_running;

    int mismatches;
    int pending;
    int items_sent  = 0;
    int scan_now    = 8;     // channels the block scans under the current setting
    bit idle_bursts = 1'b1;

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    multi_axis_step_pulse_generator u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_func           (drv.func),
        .i_motor_index    (drv.motor),
        .i_direction      (drv.dir),
        .i_steps_to_move  (drv.steps),
        .i_start_rate     (drv.start_rate),
        .i_accel_delta    (drv.accel),
        .i_decel_delta    (drv.decel),
        .i_plateau_rate   (drv.plateau),
        .i_tick_a         (drv.tick_a),
        .i_tick_b         (drv.tick_b),
        .i_tick_c         (drv.tick_c),
        .i_stop_mask      (drv.stops),
        .o_strobe         (o_strobe),
        .o_step_mask      (o_step_mask),
        .o_direction_mask (o_direction_mask),
        .o_moving_mask    (o_moving_mask),
        .o_block_done     (o_block_done),
        .o_running        (o_running)
    );

    msp_pulse_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_func           (drv.func),
        .i_motor_index    (drv.motor),
        .i_direction      (drv.dir),
        .i_steps_to_move  (drv.steps),
        .i_start_rate     (drv.start_rate),
        .i_accel_delta    (drv.accel),
        .i_decel_delta    (drv.decel),
        .i_plateau_rate   (drv.plateau),
        .i_tick_a         (drv.tick_a),
        .i_tick_b         (drv.tick_b),
        .i_tick_c         (drv.tick_c),
        .i_stop_mask      (drv.stops),
        .i_strobe         (o_strobe),
        .i_step_mask      (o_step_mask),
        .i_direction_mask (o_direction_mask),
        .i_moving_mask    (o_moving_mask),
        .i_block_done     (o_block_done),
        .i_running        (o_running),
        .o_mismatch_count (mismatches),
        .o_pending        (pending)
    );

    // ---------------------------------------------------------------
    // Transaction builders. Fields the function ignores stay random so
    // every port bit toggles without extra stimulus.
    // ---------------------------------------------------------------
    function automatic t_motion_cmd noise_cmd();
        t_motion_cmd c;
        c.func       = t_func'($urandom_range(0, 3));
        c.motor      = 3'($urandom());
        c.dir        = 1'($urandom());
        c.steps      = $urandom();
        c.start_rate = $urandom();
        c.accel      = $urandom();
        c.decel      = $urandom();
        c.plateau    = $urandom();
        c.tick_a     = $urandom();
        c.tick_b     = $urandom();
        c.tick_c     = $urandom();
        c.stops      = 8'($urandom());
        return c;
    endfunction

    function automatic t_motion_cmd tick_cmd(input logic [7:0] stops);
        t_motion_cmd c;
        c       = noise_cmd();
        c.func  = FN_TICK;
        c.stops = stops;
        return c;
    endfunction

    function automatic t_motion_cmd halt_cmd();
        t_motion_cmd c;
        c      = noise_cmd();
        c.func = FN_HALT;
        return c;
    endfunction

    function automatic t_motion_cmd start_cmd(input logic [31:0] acc_end, dec_start, total);
        t_motion_cmd c;
        c        = noise_cmd();
        c.func   = FN_START;
        c.tick_a = acc_end;
        c.tick_b = dec_start;
        c.tick_c = total;
        return c;
    endfunction

    function automatic t_motion_cmd load_cmd(input logic [2:0] motor, input logic dir,
                                             input logic [31:0] steps, sr, ad, dd, pr, ev);
        t_motion_cmd c;
        c            = noise_cmd();
        c.func       = FN_LOAD;
        c.motor      = motor;
        c.dir        = dir;
        c.steps      = steps;
        c.start_rate = sr;
        c.accel      = ad;
        c.decel      = dd;
        c.plateau    = pr;
        c.tick_a     = ev;
        return c;
    endfunction

    // Rate near a useful band; now and then anything at all.
    function automatic logic [31:0] near_rate(input int base, input int unsigned span);
        if ($urandom_range(0, 7) == 0) return $urandom();
        return base + int'($urandom_range(0, span));
    endfunction

    // Mostly short moves so blocks finish; zero and huge counts now and then.
    function automatic logic [31:0] move_length();
        case ($urandom_range(0, 19))
            0, 1:    return 32'd0;
            2:       return $urandom();
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Driving: everything changes on the falling edge; a transaction is
    // taken on the rising edge where start is high and busy is low.
    // ---------------------------------------------------------------
    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic issue(input t_motion_cmd c);
        @(negedge i_clk);
        drv   <= c;
        start <= 1'b1;
        // busy only moves on rising edges, so its value here holds until the next one
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        items_sent++;
        if ($urandom_range(0, 63) == 0) idle_bursts = !idle_bursts;
        if (idle_bursts && items_sent < ITEM_TARGET - CALM_TAIL && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 15));
    endtask

    // Drop start and wait until every predicted result has come back.
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic set_motors(input logic [3:0] value);
        settle();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        scan_now = (value > 8) ? 8 : int'(value);
    endtask

    // Config schedule: extremes first (8, 1, none, above range), then 5 and 3, then random.
    function automatic logic [3:0] phase_setting(input int phase);
        case (phase)
            0:       return 4'd8;
            1:       return 4'd1;
            2:       return 4'd0;
            3:       return 4'd15;
            4:       return 4'd5;
            5:       return 4'd3;
            default: return 4'($urandom_range(1, 8));
        endcase
    endfunction

    // One well-formed move: loads, start, a run of mostly ticks, maybe a halt.
    // Most motors take the block's accel end as their first event so the
    // plateau and decel switches actually happen.
    task automatic run_block();
        logic [31:0] acc_end;
        logic [31:0] dec_start;
        logic [31:0] total;
        logic [31:0] first_event;
        int          motor;
        acc_end   = $urandom_range(0, 10);
        dec_start = acc_end + $urandom_range(0, 12);
        // sometimes decel never starts inside the block
        total = ($urandom_range(0, 4) == 0) ? $urandom_range(0, dec_start)
                                            : dec_start + $urandom_range(1, 12);
        repeat ($urandom_range(1, 6)) begin
            if (scan_now == 0 || $urandom_range(0, 4) == 0) motor = $urandom_range(0, 7);
            else motor = $urandom_range(0, scan_now - 1);
            case ($urandom_range(0, 5))
                0:       first_event = dec_start;
                1:       first_event = $urandom_range(0, 15);
                default: first_event = acc_end;
            endcase
            issue(load_cmd(3'(motor), 1'($urandom()), move_length(),
                           near_rate(-(1 << 27), ONE_STEP + (1 << 27)),
                           near_rate(-(1 << 23), 1 << 24),
                           near_rate(-(1 << 25), 1 << 25),
                           near_rate(-(1 << 26), ONE_STEP),
                           first_event));
        end
        issue(start_cmd(acc_end, dec_start, total));
        repeat ($urandom_range(2, 36)) begin
            case ($urandom_range(0, 19))
                0:       issue(load_cmd(3'($urandom()), 1'($urandom()), $urandom_range(1, 9),
                                        ONE_STEP, 32'd0, 32'd0, ONE_STEP, 32'd0));
                1:       issue(start_cmd($urandom_range(0, 9), $urandom_range(0, 9),
                                         $urandom_range(0, 9)));
                2:       issue(tick_cmd(8'($urandom())));
                3, 4:    issue(tick_cmd(8'd1 << $urandom_range(0, 7)));
                default: issue(tick_cmd(8'h00));
            endcase
        end
        if ($urandom_range(0, 1) == 0) issue(halt_cmd());
    endtask

    // ---------------------------------------------------------------
    // Stimulus and verdict
    // ---------------------------------------------------------------
    initial begin
        int         phase;
        int         phase_end;
        logic [3:0] setting;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle corner cases
        issue(tick_cmd(8'hFF));                 // tick with nothing running
        issue(halt_cmd());                      // halt with nothing running: no done
        issue(start_cmd(32'd0, 32'd0, 32'd0));  // nothing loaded: done at once
        // extreme rates; m0 runs at the top positive rate, m2 starts negative (forced step)
        issue(load_cmd(3'd0, 1'b1, 32'd3, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'd0));
        // zero steps: direction must stay as it was
        issue(load_cmd(3'd1, 1'b1, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'hFFFF_FFFF));
        issue(load_cmd(3'd2, 1'b1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF));
        issue(load_cmd(3'd7, 1'b0, 32'd2, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1));  // zero rate
        // event at the accel end tick: switches to plateau, then decel
        issue(load_cmd(3'd5, 1'b1, 32'd4, ONE_STEP >> 1, 32'h0100_0000, 32'hFF00_0000,
                       ONE_STEP, 32'd1));
        issue(start_cmd(32'd1, 32'd3, 32'hFFFF_FFFF));
        issue(load_cmd(3'd3, 1'b1, 32'd5, ONE_STEP, 32'd0, 32'd0, 32'd0, 32'd0)); // ignored
        issue(start_cmd(32'd0, 32'd0, 32'd0));                                     // ignored
        repeat (3) issue(tick_cmd(8'h00));
        issue(tick_cmd(8'h04));                 // external stop of the endless motor
        repeat (3) issue(tick_cmd(8'h00));
        issue(halt_cmd());                      // halt after the block has already ended: no done
        issue(load_cmd(3'd4, 1'b0, 32'd1, ONE_STEP, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF));
        issue(start_cmd(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        issue(tick_cmd(8'h00));                 // single step ends the block
        issue(tick_cmd(8'h00));

        // Random: one motors_in_use setting per phase. Each phase opens with a
        // halt so a block left running cannot straddle the config write.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            issue(halt_cmd());
            setting = phase_setting(phase);
            set_motors(setting);
            phase_end = items_sent + ((setting == 4'd0) ? 60 : 240);
            while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
                if ($urandom_range(0, 4) == 0) issue(noise_cmd());
                else run_block();
            end
            phase++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: counts cycles in which neither a transaction nor a result
    // moves; a hung handshake or a missing result ends the run here.
    initial begin
        int quiet;
        quiet = 0;
        @(posedge i_rst_n);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_strobe) quiet = 0;
            else quiet++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
